// ===== rtl/core/lcs_pkg.sv =====
// LCS block package: request kinds, traceback directions, controller states
// and the control group driven into every cell of the chain.
// No dependencies.
package lcs_pkg;

  localparam int SYM_W     = 8;
  localparam int LEN_OUT_W = 7;

  typedef enum logic [1:0] {
    KIND_FIRST   = 2'd0,
    KIND_SECOND  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_MATCH = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TOTAL,
    ST_TB_ISSUE,
    ST_TB_EVAL,
    ST_EM_READ,
    ST_EM_OUT
  } state_t;

  typedef struct packed {
    logic clr;   // zero the column value before a fill
    logic ld;    // load the second-sequence symbol of this column
    logic rd;    // read the direction memory at rd_addr
  } cell_ctl_t;

endpackage

// ===== rtl/core/lcs_cell.sv =====
// One column of the LCS wavefront: holds one second-sequence symbol, the
// running table value of its column and a per-row direction memory.
// Depends on lcs_pkg.
module lcs_cell import lcs_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cell_ctl_t                          ctl,
  input  logic [SYM_W-1:0]                   ld_sym,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr,
  input  logic                               in_v,
  input  logic [SYM_W-1:0]                   in_a,
  input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] in_row,
  input  logic [$clog2(MAX_LEN+1)-1:0]       in_val,
  input  logic [$clog2(MAX_LEN+1)-1:0]       in_diag,
  output logic                               out_v,
  output logic [SYM_W-1:0]                   out_a,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] out_row,
  output logic [$clog2(MAX_LEN+1)-1:0]       out_val,
  output logic [$clog2(MAX_LEN+1)-1:0]       out_diag,
  output dir_t                               rd_dir
);

  localparam int LW = $clog2(MAX_LEN + 1);

  logic [SYM_W-1:0] b;
  dir_t             mem [MAX_LEN];
  logic             match;
  logic             up_gt;
  logic [LW-1:0]    new_val;
  dir_t             dir;

  always_comb begin
    match   = (in_a == b);
    up_gt   = (out_val > in_val);
    new_val = match ? (in_diag + LW'(1)) : (up_gt ? out_val : in_val);
    dir     = match ? DIR_MATCH : (up_gt ? DIR_UP : DIR_LEFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      out_val <= '0;
    end else if (in_v) begin
      out_val  <= new_val;
      out_diag <= out_val;
      out_a    <= in_a;
      out_row  <= in_row;
    end
    if (ctl.ld) begin
      b <= ld_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v) begin
      mem[in_row] <= dir;
    end
    if (ctl.rd) begin
      rd_dir <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/longest_common_subsequence.sv =====
// Longest common subsequence block: controller, first-sequence and result
// memories, and the chain of lcs_cell columns.
// Depends on lcs_pkg and lcs_cell.
//
// Usage: a request is taken when start is high and busy is low. kind 0
// appends symbol to the first sequence, kind 1 to the second, kind 2
// computes; kind 3 is ignored. Loads past MAX_LEN are dropped and flagged.
// A compute request fills the length table as a diagonal wavefront through
// MAX_LEN cells, one cell per column, then traces back with a direction
// memory read followed by a step each time, for at most m + n steps
// (m = first-sequence length), then emits results, each by a result memory
// read followed by a strobe. Each result is on the output ports for one
// cycle with done high; the receiver cannot stall. An empty subsequence
// gives one result with empty_res and last set. busy stays high until the
// last result is out. Compute clears both sequences and the drop flag.
// Synchronous reset returns the block to idle with empty sequences; no
// clearing pass is run.
module longest_common_subsequence import lcs_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind,
  input  logic [SYM_W-1:0]     symbol,
  output logic                 done,
  output logic [SYM_W-1:0]     out_symbol,
  output logic [LEN_OUT_W-1:0] lcs_length,
  output logic                 last,
  output logic                 empty_res,
  output logic                 overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int FW = $clog2(2 * MAX_LEN + 4);
  localparam logic [FW-1:0] DRAIN = FW'(MAX_LEN + 2);

  state_t state, state_next;

  logic [CW-1:0] fcount, scount, m, n, total, r, c, pos, k;
  logic          drop, ovf;
  logic [FW-1:0] fcnt;
  logic          accept;
  logic          rd_v;
  logic [AW-1:0] rd_row;
  logic [SYM_W-1:0] a_rd, rb_rd;
  logic [AW-1:0] a_addr;
  logic          a_rd_en;
  logic [CW-1:0] rm1, cm1, pm1, tm1;
  dir_t          cur_dir;
  logic          fill_end, tb_end, is_last;

  logic [SYM_W-1:0] aseq [MAX_LEN];
  logic [SYM_W-1:0] rbuf [MAX_LEN];

  logic             link_v    [MAX_LEN+1];
  logic [SYM_W-1:0] link_a    [MAX_LEN+1];
  logic [AW-1:0]    link_row  [MAX_LEN+1];
  logic [CW-1:0]    link_val  [MAX_LEN+1];
  logic [CW-1:0]    link_diag [MAX_LEN+1];
  dir_t             dirs      [MAX_LEN];
  cell_ctl_t        ctl       [MAX_LEN];

  assign accept = start && !busy;
  assign rm1 = r - CW'(1);
  assign cm1 = c - CW'(1);
  assign pm1 = pos - CW'(1);
  assign tm1 = total - CW'(1);
  assign cur_dir  = dirs[cm1[AW-1:0]];
  assign fill_end = (fcnt == (FW'(m) + DRAIN));
  assign tb_end   = (r == '0) || (c == '0);
  assign is_last  = (total == '0) || (k == tm1);

  // chain of cells
  assign link_v[0]    = rd_v;
  assign link_a[0]    = a_rd;
  assign link_row[0]  = rd_row;
  assign link_val[0]  = '0;
  assign link_diag[0] = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    always_comb begin
      ctl[i].clr = accept && (kind == KIND_COMPUTE);
      ctl[i].ld  = accept && (kind == KIND_SECOND) && (scount < CW'(MAX_LEN))
                   && (scount[AW-1:0] == AW'(i));
      ctl[i].rd  = (state == ST_TB_ISSUE);
    end

    lcs_cell #(.MAX_LEN(MAX_LEN)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[i]),
      .ld_sym   (symbol),
      .rd_addr  (rm1[AW-1:0]),
      .in_v     (link_v[i]),
      .in_a     (link_a[i]),
      .in_row   (link_row[i]),
      .in_val   (link_val[i]),
      .in_diag  (link_diag[i]),
      .out_v    (link_v[i+1]),
      .out_a    (link_a[i+1]),
      .out_row  (link_row[i+1]),
      .out_val  (link_val[i+1]),
      .out_diag (link_diag[i+1]),
      .rd_dir   (dirs[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept && (kind == KIND_COMPUTE)) state_next = ST_FILL;
      ST_FILL:     if (fill_end) state_next = ST_TOTAL;
      ST_TOTAL:    state_next = ST_TB_ISSUE;
      ST_TB_ISSUE: state_next = tb_end ? ST_EM_READ : ST_TB_EVAL;
      ST_TB_EVAL:  state_next = ST_TB_ISSUE;
      ST_EM_READ:  state_next = ST_EM_OUT;
      ST_EM_OUT:   state_next = is_last ? ST_IDLE : ST_EM_READ;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy       = (state != ST_IDLE);
    done       = (state == ST_EM_OUT);
    empty_res  = (total == '0);
    out_symbol = empty_res ? '0 : rb_rd;
    lcs_length = LEN_OUT_W'(total);
    last       = is_last;
    overflow   = ovf;
  end

  always_comb begin
    a_rd_en = 1'b0;
    a_addr  = fcnt[AW-1:0];
    if (state == ST_FILL) begin
      a_rd_en = 1'b1;
    end else if (state == ST_TB_ISSUE) begin
      a_rd_en = 1'b1;
      a_addr  = rm1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fcount <= '0;
      scount <= '0;
      drop   <= 1'b0;
      rd_v   <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= (state == ST_FILL) && (fcnt < FW'(m));
      if (accept) begin
        case (kind)
          KIND_FIRST: begin
            if (fcount < CW'(MAX_LEN)) fcount <= fcount + CW'(1);
            else drop <= 1'b1;
          end
          KIND_SECOND: begin
            if (scount < CW'(MAX_LEN)) scount <= scount + CW'(1);
            else drop <= 1'b1;
          end
          KIND_COMPUTE: begin
            fcount <= '0;
            scount <= '0;
            drop   <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_FIRST) && (fcount < CW'(MAX_LEN))) begin
      aseq[fcount[AW-1:0]] <= symbol;
    end
    if (a_rd_en) begin
      a_rd <= aseq[a_addr];
    end
    rd_row <= fcnt[AW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_COMPUTE)) begin
          m    <= fcount;
          n    <= scount;
          ovf  <= drop;
          fcnt <= '0;
        end
      end
      ST_FILL: fcnt <= fcnt + FW'(1);
      ST_TOTAL: begin
        total <= ((m == '0) || (n == '0)) ? '0 : link_val[n];
        pos   <= ((m == '0) || (n == '0)) ? '0 : link_val[n];
        r     <= m;
        c     <= n;
      end
      ST_TB_ISSUE: k <= '0;
      ST_TB_EVAL: begin
        if (cur_dir == DIR_MATCH) begin
          if (pos != '0) begin
            rbuf[pm1[AW-1:0]] <= a_rd;
            pos <= pm1;
          end
          r <= rm1;
          c <= cm1;
        end else if (cur_dir == DIR_UP) begin
          r <= rm1;
        end else begin
          c <= cm1;
        end
      end
      ST_EM_READ: rb_rd <= rbuf[k[AW-1:0]];
      ST_EM_OUT:  k <= k + CW'(1);
      default: ;
    endcase
  end

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && last |=> !busy) else $error("busy after last result");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    done && empty_res |-> last) else $error("empty result not marked last");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == KIND_COMPUTE) |=> busy) else $error("compute not started");

  a_tb_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TB_EVAL) |-> ($past(state) == ST_TB_ISSUE))
    else $error("traceback step without read");

endmodule

// ===== tb/longest_common_subsequence_tb.sv =====
// Testbench for longest_common_subsequence: loads random symbol sequences and
// checks every compute result against an in-bench LCS table and traceback.
// Depends on lcs_pkg and the longest_common_subsequence RTL.
`timescale 1ns / 100ps

module longest_common_subsequence_tb;
  import lcs_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int DIM     = MAX_LEN + 1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SYM_W-1:0] symbol;
  } lcs_req_t;

  typedef struct packed {
    logic [SYM_W-1:0]     out_symbol;
    logic [LEN_OUT_W-1:0] lcs_length;
    logic                 last;
    logic                 empty_res;
    logic                 overflow;
  } lcs_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           kind = '0;
  logic [SYM_W-1:0]     symbol = '0;
  logic                 done;
  logic [SYM_W-1:0]     out_symbol;
  logic [LEN_OUT_W-1:0] lcs_length;
  logic                 last;
  logic                 empty_res;
  logic                 overflow;

  longest_common_subsequence #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk, .rst, .start, .busy, .kind, .symbol,
    .done, .out_symbol, .lcs_length, .last, .empty_res, .overflow
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lcs_req_t pending_reqs[$];
  lcs_res_t expected_subseq[$];

  logic [SYM_W-1:0] seq_a[MAX_LEN];
  logic [SYM_W-1:0] seq_b[MAX_LEN];
  int               len_a, len_b;
  bit               drop_seen;
  int               mismatches, results_seen, computes_seen;
  bit               quiet_stretch;
  bit               stim_done;

  task automatic predict_lcs(input lcs_req_t req);
    int tbl[DIM][DIM];
    logic [SYM_W-1:0] subseq[MAX_LEN];
    int r, c, pos, total;
    lcs_res_t res;
    if (req.kind == KIND_FIRST) begin
      if (len_a < MAX_LEN) begin
        seq_a[len_a] = req.symbol;
        len_a++;
      end else drop_seen = 1'b1;
    end else if (req.kind == KIND_SECOND) begin
      if (len_b < MAX_LEN) begin
        seq_b[len_b] = req.symbol;
        len_b++;
      end else drop_seen = 1'b1;
    end else if (req.kind == KIND_COMPUTE) begin
      for (r = 0; r <= len_a; r++)
        for (c = 0; c <= len_b; c++)
          if (r == 0 || c == 0) tbl[r][c] = 0;
          else if (seq_a[r-1] == seq_b[c-1]) tbl[r][c] = tbl[r-1][c-1] + 1;
          else tbl[r][c] = (tbl[r-1][c] > tbl[r][c-1]) ? tbl[r-1][c] : tbl[r][c-1];
      total = tbl[len_a][len_b];
      pos = total;
      r = len_a;
      c = len_b;
      while (r > 0 && c > 0) begin
        if (seq_a[r-1] == seq_b[c-1]) begin
          pos--;
          subseq[pos] = seq_a[r-1];
          r--;
          c--;
        end else if (tbl[r-1][c] > tbl[r][c-1]) r--;
        else c--;
      end
      if (total == 0) begin
        res = '{out_symbol: '0, lcs_length: '0, last: 1'b1, empty_res: 1'b1,
                overflow: drop_seen};
        expected_subseq.push_back(res);
      end else begin
        for (int k = 0; k < total; k++) begin
          res = '{out_symbol: subseq[k], lcs_length: LEN_OUT_W'(total),
                  last: (k == total - 1), empty_res: 1'b0, overflow: drop_seen};
          expected_subseq.push_back(res);
        end
      end
      len_a = 0;
      len_b = 0;
      drop_seen = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) predict_lcs('{kind: kind, symbol: symbol});
      if (pending_reqs.size() > 0 && (quiet_stretch || $urandom_range(99) >= 17)) begin
        lcs_req_t req;
        req = pending_reqs.pop_front();
        start  <= 1'b1;
        kind   <= req.kind;
        symbol <= req.symbol;
      end else begin
        start  <= 1'b0;
        kind   <= 2'($urandom);
        symbol <= 8'($urandom);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      lcs_res_t got, exp;
      got = '{out_symbol: out_symbol, lcs_length: lcs_length, last: last,
              empty_res: empty_res, overflow: overflow};
      results_seen++;
      if (expected_subseq.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp = expected_subseq.pop_front();
        if (exp.empty_res) got.out_symbol = exp.out_symbol;
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
        end
      end
    end
  end

  task automatic add_req(input logic [1:0] k, input logic [SYM_W-1:0] s);
    pending_reqs.push_back('{kind: k, symbol: s});
  endtask

  task automatic add_seq(input int na, input int nb, input int alpha);
    for (int i = 0; i < na; i++) add_req(KIND_FIRST, 8'($urandom_range(alpha - 1)));
    for (int i = 0; i < nb; i++) add_req(KIND_SECOND, 8'($urandom_range(alpha - 1)));
    add_req(KIND_COMPUTE, 8'($urandom));
  endtask

  initial begin
    // directed: empty, one-sided, extremes, ignored kind, identical sequences
    add_req(KIND_COMPUTE, 8'hFF);
    add_req(KIND_FIRST, 8'h00);
    add_req(KIND_COMPUTE, 8'h00);
    add_req(KIND_FIRST, 8'hFF);
    add_req(KIND_SECOND, 8'hFF);
    add_req(2'd3, 8'hAA);
    add_req(KIND_FIRST, 8'h00);
    add_req(KIND_SECOND, 8'h55);
    add_req(KIND_COMPUTE, 8'h00);
    add_req(KIND_FIRST, 8'h01);
    add_req(KIND_SECOND, 8'h02);
    add_req(KIND_COMPUTE, 8'h00);
    for (int i = 0; i < 5; i++) add_req(KIND_FIRST, 8'(8'h80 >> i));
    for (int i = 0; i < 5; i++) add_req(KIND_SECOND, 8'(8'h80 >> i));
    add_req(KIND_COMPUTE, 8'h00);
    // identical full sequences, one extra symbol on each side: 64 results
    begin
      logic [SYM_W-1:0] s[MAX_LEN];
      foreach (s[i]) s[i] = 8'($urandom);
      foreach (s[i]) add_req(KIND_FIRST, s[i]);
      add_req(KIND_FIRST, 8'($urandom));
      foreach (s[i]) add_req(KIND_SECOND, s[i]);
      add_req(KIND_SECOND, 8'($urandom));
      add_req(KIND_COMPUTE, 8'h00);
    end
    // random part, mostly short sequences over small alphabets
    while (pending_reqs.size() < 280) begin
      if ($urandom_range(9) == 0) add_req(2'($urandom), 8'($urandom));
      else add_seq($urandom_range(8), $urandom_range(8),
                   ($urandom_range(3) == 0) ? 256 : $urandom_range(2, 4));
    end
    add_seq(1, 1, 256);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    quiet_stretch = 1'b0;
    wait (pending_reqs.size() < 200);
    quiet_stretch = 1'b1;
    wait (pending_reqs.size() < 100);
    quiet_stretch = 1'b0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (!start || !busy);
    @(posedge clk);
    wait (!busy && expected_subseq.size() == 0);
    repeat (20) @(posedge clk);
    $display("Checked %0d results from random and directed sequence loads;", results_seen);
    $display("covered empty, full, dropped-symbol and ignored-kind requests.");
    if (mismatches == 0 && expected_subseq.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
